/* src/markup_tag_scanner_core_defines.svh */
// ----------------------------------------------------------------------------
// Markup tag scanner assertion macros
// Shared concurrent-check shorthands; expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef MARKUP_TAG_SCANNER_CORE_DEFINES_SVH
`define MARKUP_TAG_SCANNER_CORE_DEFINES_SVH

// same-cycle implication
`define MTS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mts_pkg.sv */
// ----------------------------------------------------------------------------
// Markup tag scanner package
// Types, character constants and the per-byte phase resolution functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mts_pkg;

  localparam int OFS_BITS   = 16;
  localparam int FIELD_BITS = 16;

  localparam logic [OFS_BITS-1:0] OFS_MAX = {OFS_BITS{1'b1}};

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'd127;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_NO_BUFFER = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_SLASH  = 4'd1,
    PH_NAME0  = 4'd2,
    PH_NAME   = 4'd3,
    PH_SEP    = 4'd4,
    PH_BAD1   = 4'd5,
    PH_ATTR   = 4'd6,
    PH_BAD2   = 4'd7,
    PH_ANAME  = 4'd8,
    PH_ASP    = 4'd9,
    PH_VSP    = 4'd10,
    PH_QUOTED = 4'd11,
    PH_UNQ    = 4'd12,
    PH_TAIL   = 4'd13
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_TAKE   = 2'd1,
    ACT_FAIL   = 2'd2,
    ACT_FINISH = 2'd3
  } act_kind_t;

  typedef struct packed {
    act_kind_t kind;
    status_t   status;
    phase_t    ph;
    logic      set_slash;
    logic      inc_name;
    logic      set_attr;
    logic      set_quote;
    logic      quote_val;
  } act_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       first;
    logic       last;
  } in_word_t;

  typedef struct packed {
    status_t               status;
    logic                  closing;
    logic [FIELD_BITS-1:0] name_length;
    logic [FIELD_BITS-1:0] attr_offset;
    logic [FIELD_BITS-1:0] end_offset;
    logic                  ended_by_gt;
  } out_word_t;

  // character classes
  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_eot(logic [7:0] c);
    return (c == CH_GT) || (c == CH_LT);
  endfunction

  function automatic logic is_ident(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h5F || c == 8'h2D;
  endfunction

  function automatic logic is_atchr(logic [7:0] c);
    return (c < CH_DEL) &&
           ((c > CH_GT) || ((c > CH_SPACE) && (c != CH_EQ) && !is_eot(c)));
  endfunction

  function automatic logic is_bad(logic [7:0] c);
    return !is_atchr(c) && !is_eot(c) && !is_ws(c);
  endfunction

  // action builders
  function automatic act_t act_take(phase_t ph);
    act_t a;
    a = '0;
    a.kind = ACT_TAKE;
    a.ph = ph;
    return a;
  endfunction

  function automatic act_t act_fail(status_t st);
    act_t a;
    a = '0;
    a.kind = ACT_FAIL;
    a.status = st;
    a.ph = PH_IDLE;
    return a;
  endfunction

  function automatic act_t act_finish();
    act_t a;
    a = '0;
    a.kind = ACT_FINISH;
    a.ph = PH_IDLE;
    return a;
  endfunction

  // Each t_* settles the byte starting from that phase, following the
  // fall-through chain until the byte is taken, ends the tag, or fails.
  function automatic act_t t_bad2(logic [7:0] c);
    act_t a;
    if (is_bad(c)) a = act_take(PH_BAD2);
    else if (is_eot(c)) a = act_finish();
    else if (is_atchr(c)) a = act_take(PH_ANAME);
    else a = act_take(PH_ASP);
    return a;
  endfunction

  function automatic act_t t_attr(logic [7:0] c);
    act_t a;
    if (is_ws(c)) a = act_take(PH_ATTR);
    else a = t_bad2(c);
    return a;
  endfunction

  function automatic act_t t_asp(logic [7:0] c);
    act_t a;
    if (is_ws(c)) a = act_take(PH_ASP);
    else if (c == CH_EQ) a = act_take(PH_VSP);
    else if (is_eot(c)) a = act_finish();
    else a = t_attr(c);
    return a;
  endfunction

  function automatic act_t t_aname(logic [7:0] c);
    act_t a;
    if (is_atchr(c)) a = act_take(PH_ANAME);
    else a = t_asp(c);
    return a;
  endfunction

  function automatic act_t t_tail(logic [7:0] c);
    act_t a;
    if (is_ws(c)) a = act_take(PH_TAIL);
    else if (is_eot(c)) a = act_finish();
    else a = t_attr(c);
    return a;
  endfunction

  function automatic act_t t_unq(logic [7:0] c);
    act_t a;
    if (!is_ws(c) && !is_eot(c)) a = act_take(PH_UNQ);
    else a = t_tail(c);
    return a;
  endfunction

  function automatic act_t t_vsp(logic [7:0] c);
    act_t a;
    if (is_ws(c)) begin
      a = act_take(PH_VSP);
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      a = act_take(PH_QUOTED);
      a.set_quote = 1'b1;
      a.quote_val = (c == CH_SQUOTE);
    end else begin
      a = t_unq(c);
    end
    return a;
  endfunction

  function automatic act_t t_quoted(logic [7:0] c, logic single);
    act_t a;
    if (c == (single ? CH_SQUOTE : CH_DQUOTE)) a = act_take(PH_TAIL);
    else a = act_take(PH_QUOTED);
    return a;
  endfunction

  function automatic act_t t_bad1(logic [7:0] c);
    act_t a;
    if (is_bad(c)) begin
      a = act_take(PH_BAD1);
    end else begin
      a = t_attr(c);
      a.set_attr = 1'b1;
    end
    return a;
  endfunction

  function automatic act_t t_sep(logic [7:0] c);
    act_t a;
    if (is_ws(c) || c == CH_SLASH || c == CH_COLON) a = act_take(PH_SEP);
    else a = t_bad1(c);
    return a;
  endfunction

  function automatic act_t t_name(logic [7:0] c);
    act_t a;
    if (is_ident(c)) begin
      a = act_take(PH_NAME);
      a.inc_name = 1'b1;
    end else if (!is_ws(c) && !is_eot(c) && c != CH_SLASH && c != CH_COLON &&
                 c != CH_EQ) begin
      a = act_fail(ST_MALFORMED);
    end else begin
      a = t_sep(c);
    end
    return a;
  endfunction

  function automatic act_t t_name0(logic [7:0] c);
    act_t a;
    if (!is_ident(c)) a = act_fail(ST_MALFORMED);
    else a = t_name(c);
    return a;
  endfunction

  function automatic act_t t_slash(logic [7:0] c);
    act_t a;
    if (c == CH_SLASH) begin
      a = act_take(PH_NAME0);
      a.set_slash = 1'b1;
    end else begin
      a = t_name0(c);
    end
    return a;
  endfunction

  function automatic act_t resolve(phase_t ph, logic [7:0] c, logic single);
    act_t a;
    unique case (ph)
      PH_SLASH:  a = t_slash(c);
      PH_NAME0:  a = t_name0(c);
      PH_NAME:   a = t_name(c);
      PH_SEP:    a = t_sep(c);
      PH_BAD1:   a = t_bad1(c);
      PH_ATTR:   a = t_attr(c);
      PH_BAD2:   a = t_bad2(c);
      PH_ANAME:  a = t_aname(c);
      PH_ASP:    a = t_asp(c);
      PH_VSP:    a = t_vsp(c);
      PH_QUOTED: a = t_quoted(c, single);
      PH_UNQ:    a = t_unq(c);
      PH_TAIL:   a = t_tail(c);
      default: begin
        a = '0;
        a.kind = ACT_NONE;
        a.ph = PH_IDLE;
      end
    endcase
    return a;
  endfunction

endpackage

/* src/mts_in_if.sv */
// ----------------------------------------------------------------------------
// Markup tag scanner byte channel
// Valid/ready channel carrying one buffer byte and its framing flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       first;
  logic       last;

  modport source (output valid, output byte_in, output first, output last,
                  input ready);
  modport sink (input valid, input byte_in, input first, input last,
                output ready);
endinterface

/* src/mts_out_if.sv */
// ----------------------------------------------------------------------------
// Markup tag scanner result channel
// Valid/ready channel carrying one scan result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        closing;
  logic [15:0] name_length;
  logic [15:0] attr_offset;
  logic [15:0] end_offset;
  logic        ended_by_gt;

  modport source (output valid, output status, output closing, output name_length,
                  output attr_offset, output end_offset, output ended_by_gt,
                  input ready);
  modport sink (input valid, input status, input closing, input name_length,
                input attr_offset, input end_offset, input ended_by_gt,
                output ready);
endinterface

/* src/mts_in_stage.sv */
// ----------------------------------------------------------------------------
// Markup tag scanner input register
// Captures one byte word; refills in the same cycle the engine consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_in_stage (
  input  logic              clk,
  input  logic              rst,
  mts_in_if.sink            bytes,
  input  logic              consume,
  output logic              word_valid,
  output mts_pkg::in_word_t word
);
  import mts_pkg::*;

  assign bytes.ready = !word_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      word_valid <= 1'b1;
    end else if (consume) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      word.byte_in <= bytes.byte_in;
      word.first   <= bytes.first;
      word.last    <= bytes.last;
    end
  end

endmodule

/* src/mts_scan_engine.sv */
// ----------------------------------------------------------------------------
// Markup tag scanner engine
// Per-byte phase update, offset counters and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "markup_tag_scanner_core_defines.svh"

module mts_scan_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              word_valid,
  input  mts_pkg::in_word_t word,
  output logic              consume,
  mts_out_if.source         tags
);
  import mts_pkg::*;

  phase_t              phase, phase_next;
  logic                quote_is_single, quote_is_single_next;
  logic [OFS_BITS-1:0] position, position_next;
  logic [OFS_BITS-1:0] name_count, name_count_next;
  logic [OFS_BITS-1:0] attr_start, attr_start_next;
  logic                slash_seen, slash_seen_next;

  logic      out_valid;
  out_word_t out_word, res;
  logic      emit;
  act_t      act;
  logic      at_max;
  logic      is_gt;
  logic      take_ok;
  logic      open_ok;
  logic      fail_clean;

  logic [OFS_BITS-1:0] attr_eff;
  logic [OFS_BITS:0]   end_pos;

  assign consume = word_valid && (!out_valid || tags.ready);
  assign act     = resolve(phase, word.byte_in, quote_is_single);
  assign at_max  = (position == OFS_MAX);
  assign is_gt   = (word.byte_in == CH_GT);
  assign open_ok = (word.byte_in == CH_LT) && !word.last;
  assign take_ok = (act.kind == ACT_TAKE) && !word.last && !at_max;
  assign attr_eff = act.set_attr ? position : attr_start;
  assign end_pos  = {1'b0, position} + {{OFS_BITS{1'b0}}, is_gt};

  // next phase
  always_comb begin
    phase_next = phase;
    if (word.first) begin
      phase_next = open_ok ? PH_SLASH : PH_IDLE;
    end else if (phase != PH_IDLE) begin
      phase_next = take_ok ? act.ph : PH_IDLE;
    end
  end

  // counters and result
  always_comb begin
    quote_is_single_next = quote_is_single;
    position_next        = position;
    name_count_next      = name_count;
    attr_start_next      = attr_start;
    slash_seen_next      = slash_seen;
    emit = 1'b0;
    res  = '0;
    if (word.first) begin
      quote_is_single_next = 1'b0;
      name_count_next      = '0;
      attr_start_next      = '0;
      slash_seen_next      = 1'b0;
      position_next        = open_ok ? {{(OFS_BITS-1){1'b0}}, 1'b1} : '0;
      if (word.byte_in != CH_LT) begin
        emit = 1'b1;
        res.status = ST_MALFORMED;
      end else if (word.last) begin
        emit = 1'b1;
        res.status = ST_NO_BUFFER;
      end
    end else if (phase != PH_IDLE) begin
      unique case (act.kind)
        ACT_TAKE: begin
          if (word.last) begin
            emit = 1'b1;
            res.status = ST_NO_BUFFER;
          end else if (at_max) begin
            emit = 1'b1;
            res.status = ST_OVERFLOW;
          end else begin
            position_next = position + 1'b1;
            if (act.inc_name) name_count_next = name_count + 1'b1;
            if (act.set_attr) attr_start_next = position;
            if (act.set_slash) slash_seen_next = 1'b1;
            if (act.set_quote) quote_is_single_next = act.quote_val;
          end
        end
        ACT_FAIL: begin
          emit = 1'b1;
          res.status = act.status;
        end
        ACT_FINISH: begin
          emit = 1'b1;
          if (is_gt && at_max) begin
            res.status = ST_OVERFLOW;
          end else begin
            res.status      = ST_OK;
            res.closing     = slash_seen;
            res.name_length = FIELD_BITS'(name_count);
            res.attr_offset = FIELD_BITS'(attr_eff);
            res.end_offset  = FIELD_BITS'(end_pos);
            res.ended_by_gt = is_gt;
          end
        end
        ACT_NONE: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      quote_is_single <= 1'b0;
      position        <= '0;
      name_count      <= '0;
      attr_start      <= '0;
      slash_seen      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (consume) begin
        phase           <= phase_next;
        quote_is_single <= quote_is_single_next;
        position        <= position_next;
        name_count      <= name_count_next;
        attr_start      <= attr_start_next;
        slash_seen      <= slash_seen_next;
        out_valid       <= emit;
      end else if (tags.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && emit) begin
      out_word <= res;
    end
  end

  assign tags.valid       = out_valid;
  assign tags.status      = out_word.status;
  assign tags.closing     = out_word.closing;
  assign tags.name_length = out_word.name_length;
  assign tags.attr_offset = out_word.attr_offset;
  assign tags.end_offset  = out_word.end_offset;
  assign tags.ended_by_gt = out_word.ended_by_gt;

  assign fail_clean = !out_word.closing && out_word.name_length == '0 &&
                      out_word.attr_offset == '0 && out_word.end_offset == '0 &&
                      !out_word.ended_by_gt;

  `MTS_ASSERT(a_fail_fields_zero, out_valid && out_word.status != ST_OK, fail_clean, "failed result carries nonzero fields")
  `MTS_ASSERT_NEXT(a_emit_goes_idle, consume && emit, phase == PH_IDLE, "scan not idle after result")
  `MTS_ASSERT(a_name_within_pos, 1'b1, name_count <= position, "name count ran past position")
  `MTS_ASSERT(a_attr_within_pos, 1'b1, attr_start <= position, "attribute start ran past position")

endmodule

/* src/markup_tag_scanner_core.sv */
// ----------------------------------------------------------------------------
// Markup tag scanner core
// Streaming scanner that validates one markup element per flagged start byte.
// ----------------------------------------------------------------------------
// Takes one byte word per cycle, back to back, while results are taken, and
// answers each finished or failed element with one result word; the byte
// that ends it passes through the input register and then the result
// register. The throughput is one byte per clock while results drain, set by
// the scanner state update that every byte passes through; a stalled result
// stops intake only once the input register is also full.
`timescale 1ns / 1ps

module markup_tag_scanner_core (
  input  logic       clk,
  input  logic       rst,
  mts_in_if.sink     bytes,
  mts_out_if.source  tags
);
  import mts_pkg::*;

  logic     word_valid;
  in_word_t word;
  logic     consume;

  mts_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .consume    (consume),
    .word_valid (word_valid),
    .word       (word)
  );

  mts_scan_engine u_scan_engine (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word       (word),
    .consume    (consume),
    .tags       (tags)
  );

endmodule

/* tb/tb_markup_tag_scanner_core.sv */
// ----------------------------------------------------------------------------
// Markup tag scanner core testbench
// Streams directed and random markup elements through the byte channel under
// changing idle and stall patterns, predicts every scan result in step with
// the accepted bytes and checks each result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_markup_tag_scanner_core;
  import mts_pkg::*;

  typedef enum logic [1:0] {
    PACE_CALM       = 2'd0,
    PACE_SEND_GAPS  = 2'd1,
    PACE_RECV_STALL = 2'd2,
    PACE_BOTH       = 2'd3
  } pace_t;

  typedef enum int {
    CLS_JUNK,
    CLS_ATTR,
    CLS_UNQ
  } byte_class_t;

  typedef struct packed {
    logic [7:0] b;
    logic       f;
    logic       l;
    pace_t      pace;
  } byte_item_t;

  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_BYTES   = 300;
  localparam int DRAIN_CYCLES  = 16;
  localparam int REPORT_LIMIT  = 10;

  logic clk = 1'b0;
  logic rst;

  mts_in_if  bytes_if ();
  mts_out_if tags_if ();

  markup_tag_scanner_core u_top (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes_if),
    .tags  (tags_if)
  );

  always #4 clk = ~clk;

  byte_item_t byte_plan[$];
  out_word_t  tag_expect[$];
  pace_t      cur_pace;
  int         bytes_taken;
  int         err_count;
  int         quiet;

  // scanner state as seen by the predictor
  phase_t      tag_phase;
  logic        quote_single;
  logic [15:0] scan_pos;
  logic [15:0] name_len;
  logic [15:0] attr_pos;
  logic        slash_flag;

  // character classes
  function automatic logic ch_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic ch_delim(logic [7:0] c);
    return (c == CH_GT) || (c == CH_LT);
  endfunction

  function automatic logic ch_ident(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || (c == "_") || (c == "-");
  endfunction

  function automatic logic ch_attr(logic [7:0] c);
    if (c >= CH_DEL) return 1'b0;
    if (c > CH_GT) return 1'b1;
    return (c > CH_SPACE) && (c != CH_EQ) && !ch_delim(c);
  endfunction

  function automatic logic ch_junk(logic [7:0] c);
    return !ch_attr(c) && !ch_delim(c) && !ch_space(c);
  endfunction

  function automatic logic class_ok(logic [7:0] c, byte_class_t cls);
    case (cls)
      CLS_JUNK: return ch_junk(c);
      CLS_ATTR: return ch_attr(c);
      default:  return !ch_space(c) && !ch_delim(c);
    endcase
  endfunction

  function automatic logic [7:0] pick_class(byte_class_t cls);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (!class_ok(b, cls));
    return b;
  endfunction

  function automatic logic [7:0] pick_ident();
    int k;
    k = $urandom_range(63);
    if (k < 26) return 8'("a" + k);
    if (k < 52) return 8'("A" + k - 26);
    if (k < 62) return 8'("0" + k - 52);
    return (k == 62) ? 8'("_") : 8'("-");
  endfunction

  function automatic logic [7:0] pick_space();
    int k;
    k = $urandom_range(6);
    return (k == 6) ? CH_SPACE : 8'(9 + k);
  endfunction

  function automatic logic [7:0] pick_sep();
    int k;
    k = $urandom_range(2);
    if (k == 0) return pick_space();
    return (k == 1) ? CH_SLASH : CH_COLON;
  endfunction

  function automatic int gap_pct(pace_t p);
    if (p == PACE_SEND_GAPS) return 74;
    if (p == PACE_BOTH) return 21;
    return 0;
  endfunction

  function automatic int stall_pct(pace_t p);
    if (p == PACE_RECV_STALL) return 74;
    if (p == PACE_BOTH) return 21;
    return 0;
  endfunction

  // ---------------------------------------------------------------- predictor
  task automatic emit_tag(input status_t st, input logic cl, input logic [15:0] nl,
                          input logic [15:0] ao, input logic [15:0] eo, input logic gt);
    out_word_t w;
    w.status      = st;
    w.closing     = cl;
    w.name_length = nl;
    w.attr_offset = ao;
    w.end_offset  = eo;
    w.ended_by_gt = gt;
    tag_expect.push_back(w);
    tag_phase = PH_IDLE;
  endtask

  task automatic post_fail(input status_t st);
    emit_tag(st, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
  endtask

  // step past the current byte; buffer end wins over offset overflow
  task automatic advance(input logic lst);
    if (lst) begin
      post_fail(ST_NO_BUFFER);
    end else if (scan_pos >= OFS_MAX) begin
      post_fail(ST_OVERFLOW);
    end else begin
      scan_pos = scan_pos + 16'd1;
    end
  endtask

  task automatic close_tag(input logic [7:0] c);
    logic gt;
    gt = (c == CH_GT);
    if (gt && scan_pos >= OFS_MAX) begin
      post_fail(ST_OVERFLOW);
    end else begin
      emit_tag(ST_OK, slash_flag, name_len, attr_pos, scan_pos + {15'd0, gt}, gt);
    end
  endtask

  task automatic scan_byte(input logic [7:0] c, input logic fst, input logic lst);
    int   guard;
    logic done;
    if (fst) begin
      tag_phase    = PH_IDLE;
      quote_single = 1'b0;
      scan_pos     = 16'd0;
      name_len     = 16'd0;
      attr_pos     = 16'd0;
      slash_flag   = 1'b0;
      if (c != CH_LT) begin
        post_fail(ST_MALFORMED);
      end else begin
        tag_phase = PH_SLASH;
        advance(lst);
      end
      return;
    end
    done = (tag_phase == PH_IDLE);
    // a byte may fall through several phases before it is settled
    for (guard = 0; guard < 32 && !done; guard++) begin
      done = 1'b1;
      case (tag_phase)
        PH_SLASH: begin
          tag_phase = PH_NAME0;
          if (c == CH_SLASH) begin
            slash_flag = 1'b1;
            advance(lst);
          end else begin
            done = 1'b0;
          end
        end
        PH_NAME0: begin
          if (!ch_ident(c)) begin
            post_fail(ST_MALFORMED);
          end else begin
            tag_phase = PH_NAME;
            done = 1'b0;
          end
        end
        PH_NAME: begin
          if (ch_ident(c)) begin
            name_len = name_len + 16'd1;
            advance(lst);
          end else if (!ch_space(c) && !ch_delim(c) && c != CH_SLASH &&
                       c != CH_COLON && c != CH_EQ) begin
            post_fail(ST_MALFORMED);
          end else begin
            tag_phase = PH_SEP;
            done = 1'b0;
          end
        end
        PH_SEP: begin
          if (ch_space(c) || c == CH_SLASH || c == CH_COLON) begin
            advance(lst);
          end else begin
            tag_phase = PH_BAD1;
            done = 1'b0;
          end
        end
        PH_BAD1: begin
          if (ch_junk(c)) begin
            advance(lst);
          end else begin
            attr_pos = scan_pos;
            tag_phase = PH_ATTR;
            done = 1'b0;
          end
        end
        PH_ATTR: begin
          if (ch_space(c)) begin
            advance(lst);
          end else begin
            tag_phase = PH_BAD2;
            done = 1'b0;
          end
        end
        PH_BAD2: begin
          if (ch_junk(c)) begin
            advance(lst);
          end else if (ch_delim(c)) begin
            close_tag(c);
          end else begin
            tag_phase = PH_ANAME;
            done = 1'b0;
          end
        end
        PH_ANAME: begin
          if (ch_attr(c)) begin
            advance(lst);
          end else begin
            tag_phase = PH_ASP;
            done = 1'b0;
          end
        end
        PH_ASP: begin
          if (ch_space(c)) begin
            advance(lst);
          end else if (c == CH_EQ) begin
            tag_phase = PH_VSP;
            advance(lst);
          end else if (ch_delim(c)) begin
            close_tag(c);
          end else begin
            tag_phase = PH_ATTR;
            done = 1'b0;
          end
        end
        PH_VSP: begin
          if (ch_space(c)) begin
            advance(lst);
          end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            quote_single = (c == CH_SQUOTE);
            tag_phase = PH_QUOTED;
            advance(lst);
          end else begin
            tag_phase = PH_UNQ;
            done = 1'b0;
          end
        end
        PH_QUOTED: begin
          if (c == (quote_single ? CH_SQUOTE : CH_DQUOTE)) tag_phase = PH_TAIL;
          advance(lst);
        end
        PH_UNQ: begin
          if (!ch_space(c) && !ch_delim(c)) begin
            advance(lst);
          end else begin
            tag_phase = PH_TAIL;
            done = 1'b0;
          end
        end
        PH_TAIL: begin
          if (ch_space(c)) begin
            advance(lst);
          end else if (ch_delim(c)) begin
            close_tag(c);
          end else begin
            tag_phase = PH_ATTR;
            done = 1'b0;
          end
        end
        default: tag_phase = PH_IDLE;
      endcase
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic plan_byte(input logic [7:0] b, input logic f, input logic l,
                           input pace_t pace);
    byte_item_t it;
    it.b    = b;
    it.f    = f;
    it.l    = l;
    it.pace = pace;
    byte_plan.push_back(it);
  endtask

  // one mostly well-formed element with random content, mutations and noise
  task automatic plan_element(input pace_t pace, inout int count);
    logic [7:0] el[$];
    logic [7:0] q;
    logic [7:0] q2;
    int         n, k, a, j, cut;
    logic       f;
    el.push_back(CH_LT);
    if ($urandom_range(1) == 1) el.push_back(CH_SLASH);
    n = ($urandom_range(19) == 0) ? 0 : $urandom_range(6, 1);
    for (k = 0; k < n; k++) el.push_back(pick_ident());
    case ($urandom_range(9))
      0, 1, 2, 3: el.push_back(pick_space());
      4: el.push_back(CH_SLASH);
      5: el.push_back(CH_COLON);
      6: el.push_back(CH_EQ);
      7: el.push_back(pick_class(CLS_JUNK));
      default: ;
    endcase
    n = $urandom_range(2);
    for (k = 0; k < n; k++) el.push_back(pick_sep());
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(2, 1);
      for (k = 0; k < n; k++) el.push_back(pick_class(CLS_JUNK));
    end
    a = $urandom_range(3);
    for (j = 0; j < a; j++) begin
      n = $urandom_range(4, 1);
      for (k = 0; k < n; k++) el.push_back(pick_class(CLS_ATTR));
      if ($urandom_range(2) == 0) el.push_back(pick_space());
      if ($urandom_range(3) != 0) begin
        el.push_back(CH_EQ);
        if ($urandom_range(2) == 0) el.push_back(pick_space());
        if ($urandom_range(2) != 0) begin
          q = ($urandom_range(1) == 1) ? CH_SQUOTE : CH_DQUOTE;
          el.push_back(q);
          n = $urandom_range(4);
          for (k = 0; k < n; k++) begin
            do q2 = 8'($urandom_range(255)); while (q2 == q);
            el.push_back(q2);
          end
          el.push_back(q);
        end else begin
          n = $urandom_range(4, 1);
          for (k = 0; k < n; k++) el.push_back(pick_class(CLS_UNQ));
        end
      end
      if ($urandom_range(4) != 0) el.push_back(pick_space());
      else if ($urandom_range(1) == 1) el.push_back(pick_class(CLS_JUNK));
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5, 6: el.push_back(CH_GT);
      7, 8: el.push_back(CH_LT);
      default: ;
    endcase
    for (k = 0; k < el.size(); k++) begin
      if ($urandom_range(39) == 0) el[k] = 8'($urandom_range(255));
    end
    cut = -1;
    if ($urandom_range(9) == 0) cut = el.size() - 1;
    else if ($urandom_range(19) == 0) cut = $urandom_range(el.size() - 1, 0);
    for (k = 0; k < el.size() && (cut < 0 || k <= cut); k++) begin
      // now and then a stray start flag restarts the scan mid element
      f = (k == 0) || ($urandom_range(59) == 0);
      plan_byte(el[k], f, k == cut, pace);
      count++;
    end
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(3, 1);
      for (k = 0; k < n; k++) begin
        plan_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), pace);
      end
    end
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drive_bytes
    byte_item_t nxt;
    if (rst) begin
      bytes_if.valid   <= 1'b0;
      bytes_if.byte_in <= 8'd0;
      bytes_if.first   <= 1'b0;
      bytes_if.last    <= 1'b0;
    end else begin
      if (bytes_if.valid && bytes_if.ready) begin
        scan_byte(bytes_if.byte_in, bytes_if.first, bytes_if.last);
        bytes_taken++;
      end
      if (!bytes_if.valid || bytes_if.ready) begin
        if (byte_plan.size() != 0 && $urandom_range(99) >= gap_pct(byte_plan[0].pace)) begin
          nxt = byte_plan.pop_front();
          bytes_if.valid   <= 1'b1;
          bytes_if.byte_in <= nxt.b;
          bytes_if.first   <= nxt.f;
          bytes_if.last    <= nxt.l;
          cur_pace         <= nxt.pace;
        end else begin
          bytes_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) tags_if.ready <= 1'b0;
    else tags_if.ready <= ($urandom_range(99) >= stall_pct(cur_pace));
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : check_tags
    out_word_t want;
    if (!rst && tags_if.valid && tags_if.ready) begin
      if (tag_expect.size() == 0) begin
        if (err_count < REPORT_LIMIT)
          $display("tag word with nothing pending: st=%0d cl=%0d nl=%0d ao=%0d eo=%0d gt=%0d",
                   tags_if.status, tags_if.closing, tags_if.name_length,
                   tags_if.attr_offset, tags_if.end_offset, tags_if.ended_by_gt);
        err_count++;
      end else begin
        want = tag_expect.pop_front();
        if (tags_if.status !== want.status || tags_if.closing !== want.closing ||
            tags_if.name_length !== want.name_length ||
            tags_if.attr_offset !== want.attr_offset ||
            tags_if.end_offset !== want.end_offset ||
            tags_if.ended_by_gt !== want.ended_by_gt) begin
          if (err_count < REPORT_LIMIT) begin
            $display("tag mismatch exp: st=%0d cl=%0d nl=%0d ao=%0d eo=%0d gt=%0d",
                     want.status, want.closing, want.name_length,
                     want.attr_offset, want.end_offset, want.ended_by_gt);
            $display("             got: st=%0d cl=%0d nl=%0d ao=%0d eo=%0d gt=%0d",
                     tags_if.status, tags_if.closing, tags_if.name_length,
                     tags_if.attr_offset, tags_if.end_offset, tags_if.ended_by_gt);
          end
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst || (bytes_if.valid && bytes_if.ready) || (tags_if.valid && tags_if.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("markup_tag_scanner_core verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin : run_plan
    pace_t      paces[4];
    int         p, cnt, total;
    bytes_if.valid   = 1'b0;
    bytes_if.byte_in = 8'd0;
    bytes_if.first   = 1'b0;
    bytes_if.last    = 1'b0;
    tags_if.ready    = 1'b0;
    cur_pace         = PACE_CALM;
    bytes_taken      = 0;
    err_count        = 0;
    quiet            = 0;
    tag_phase        = PH_IDLE;
    quote_single     = 1'b0;
    scan_pos         = 16'd0;
    name_len         = 16'd0;
    attr_pos         = 16'd0;
    slash_flag       = 1'b0;
    rst              = 1'b1;

    // directed: idle byte, missing opening, closing tag with quoted attribute
    plan_byte(8'h00, 1'b0, 1'b0, PACE_CALM);
    plan_byte("x", 1'b1, 1'b0, PACE_CALM);
    plan_byte(CH_LT, 1'b1, 1'b0, PACE_CALM);
    plan_byte(CH_SLASH, 1'b0, 1'b0, PACE_CALM);
    plan_byte("Z", 1'b0, 1'b0, PACE_CALM);
    plan_byte(CH_SPACE, 1'b0, 1'b0, PACE_CALM);
    plan_byte("x", 1'b0, 1'b0, PACE_CALM);
    plan_byte(CH_EQ, 1'b0, 1'b0, PACE_CALM);
    plan_byte(CH_SQUOTE, 1'b0, 1'b0, PACE_CALM);
    plan_byte("y", 1'b0, 1'b0, PACE_CALM);
    plan_byte(CH_SQUOTE, 1'b0, 1'b0, PACE_CALM);
    plan_byte(CH_GT, 1'b0, 1'b0, PACE_CALM);
    // restart in mid scan
    plan_byte(CH_LT, 1'b1, 1'b0, PACE_CALM);
    plan_byte("a", 1'b0, 1'b0, PACE_CALM);
    plan_byte(CH_LT, 1'b1, 1'b0, PACE_CALM);
    plan_byte("b", 1'b0, 1'b0, PACE_CALM);
    plan_byte(CH_GT, 1'b0, 1'b0, PACE_CALM);
    // buffer end on the opening byte
    plan_byte(CH_LT, 1'b1, 1'b1, PACE_CALM);
    // stopped by a following '<'
    plan_byte(CH_LT, 1'b1, 1'b0, PACE_CALM);
    plan_byte("q", 1'b0, 1'b0, PACE_CALM);
    plan_byte(CH_LT, 1'b0, 1'b0, PACE_CALM);
    plan_byte(8'hFF, 1'b1, 1'b1, PACE_CALM);

    paces = '{PACE_CALM, PACE_SEND_GAPS, PACE_RECV_STALL, PACE_BOTH};
    for (p = 0; p < 4; p++) begin
      cnt = 0;
      while (cnt < PHASE_BYTES) plan_element(paces[p], cnt);
    end
    total = byte_plan.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken != total || tag_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0 && tag_expect.size() == 0) begin
      $display("markup_tag_scanner_core verification clean");
    end else begin
      $display("markup_tag_scanner_core verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/mts_pkg.sv
src/mts_in_if.sv
src/mts_out_if.sv
src/mts_in_stage.sv
src/mts_scan_engine.sv
src/markup_tag_scanner_core.sv
tb/tb_markup_tag_scanner_core.sv
